>>> src/stt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

    // Pending token kinds held between bytes.
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_WORD  = 3'd1,
        MODE_NUM   = 3'd2,
        MODE_COLON = 3'd3,
        MODE_EQ1   = 3'd4,
        MODE_EQ2   = 3'd5,
        MODE_OP    = 3'd6,
        MODE_SEMI  = 3'd7
    } t_mode;

    localparam logic [2:0] ST_TOKEN        = 3'd0;
    localparam logic [2:0] ST_COLON_SPACE  = 3'd1;
    localparam logic [2:0] ST_BAD_EQUALS   = 3'd2;
    localparam logic [2:0] ST_BAD_OPERATOR = 3'd3;
    localparam logic [2:0] ST_DIGIT_LETTER = 3'd4;
    localparam logic [2:0] ST_SEMI_NEWLINE = 3'd5;
    localparam logic [2:0] ST_INVALID_CHAR = 3'd6;

    localparam logic [3:0] KIND_KEYWORD    = 4'd0;
    localparam logic [3:0] KIND_IDENTIFIER = 4'd1;
    localparam logic [3:0] KIND_OPERATOR   = 4'd2;
    localparam logic [3:0] KIND_ASSIGN     = 4'd3;
    localparam logic [3:0] KIND_COMPARE    = 4'd4;
    localparam logic [3:0] KIND_INTEGER    = 4'd5;
    localparam logic [3:0] KIND_SEMICOLON  = 4'd6;
    localparam logic [3:0] KIND_COLON      = 4'd7;
    localparam logic [3:0] KIND_LPAREN     = 4'd8;
    localparam logic [3:0] KIND_RPAREN     = 4'd9;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    localparam int          KW_COUNT     = 8;
    localparam int          KW_MAX_LEN   = 5;
    localparam logic [15:0] LENGTH_MAX   = 16'hFFFF;

    // Keywords packed big-endian, first letter in the most significant used byte.
    localparam logic [39:0] KW_VALUE [KW_COUNT] = '{
        40'h00_006C_6574,
        40'h77_6869_6C65,
        40'h00_0000_6966,
        40'h00_656C_7365,
        40'h00_0069_6E74,
        40'h66_6C6F_6174,
        40'h00_6368_6172,
        40'h00_0000_666E
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd2, 3'd4, 3'd3, 3'd5, 3'd4, 3'd2
    };

    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = 2;
    localparam int FIFO_CNT_BITS  = 3;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic [2:0]  keyword_index;
        logic [7:0]  operator_char;
        logic        last_of_run;
    } t_result;

    // Results produced by one input transaction, first in order first.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic t_result make_result(
        input logic [2:0]  status,
        input logic [3:0]  kind,
        input logic [15:0] start,
        input logic [15:0] length,
        input logic [15:0] line,
        input logic [2:0]  kw,
        input logic [7:0]  op
    );
        t_result r;
        r.status        = status;
        r.token_kind    = kind;
        r.token_start   = start;
        r.token_length  = length;
        r.line_number   = line;
        r.keyword_index = kw;
        r.operator_char = op;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/stt_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

>>> src/stt_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [2:0]  keyword_index;
    logic [7:0]  operator_char;
    logic        last_of_run;

    modport source (
        output valid, output status, output token_kind, output token_start,
        output token_length, output line_number, output keyword_index,
        output operator_char, output last_of_run, input ready
    );
    modport sink (
        input valid, input status, input token_kind, input token_start,
        input token_length, input line_number, input keyword_index,
        input operator_char, input last_of_run, output ready
    );
endinterface

`default_nettype wire

>>> src/source_text_tokenizer.sv
// Results: the results of an accepted byte are written into the registered result queue.
// Throughput: one byte per cycle while the queue has room; the result queue drains one
// token per cycle while the receiver is ready, so a byte that causes two results takes two
// output transfers, and input is held off while more than two results wait in the four-entry queue.
// Reset: synchronous, active low; clears position, line, pending token, error halt and
// empties the result queue.
`timescale 1ns / 1ps
`default_nettype none

module source_text_tokenizer #(
    parameter int POSITION_BITS = 16,
    parameter int LINE_BITS     = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    stt_in_if.sink      i_text,
    stt_out_if.source   o_tok
);

    logic               w_accept;
    logic               w_room;
    stt_pkg::t_push     w_push;
    stt_pkg::t_result   w_head;

    assign i_text.ready = w_room;
    assign w_accept     = i_text.valid & w_room;

    stt_core #(
        .POSITION_BITS (POSITION_BITS),
        .LINE_BITS     (LINE_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_text_byte   (i_text.text_byte),
        .i_end_of_text (i_text.end_of_text),
        .o_push        (w_push)
    );

    stt_result_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (w_accept),
        .i_push    (w_push),
        .o_room    (w_room),
        .o_valid   (o_tok.valid),
        .o_head    (w_head),
        .i_pop     (o_tok.ready)
    );

    assign o_tok.status        = w_head.status;
    assign o_tok.token_kind    = w_head.token_kind;
    assign o_tok.token_start   = w_head.token_start;
    assign o_tok.token_length  = w_head.token_length;
    assign o_tok.line_number   = w_head.line_number;
    assign o_tok.keyword_index = w_head.keyword_index;
    assign o_tok.operator_char = w_head.operator_char;
    assign o_tok.last_of_run   = w_head.last_of_run;

endmodule

`default_nettype wire

>>> src/stt_core.sv
`timescale 1ns / 1ps
`default_nettype none

module stt_core #(
    parameter int POSITION_BITS = 16,
    parameter int LINE_BITS     = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_text_byte,
    input  wire logic          i_end_of_text,
    output stt_pkg::t_push     o_push
);

    stt_pkg::t_mode               r_mode, n_mode;
    logic [POSITION_BITS-1:0]     r_pos, n_pos;
    logic [LINE_BITS-1:0]         r_line, n_line;
    logic [POSITION_BITS-1:0]     r_start, n_start;
    logic [15:0]                  r_len, n_len;
    logic [39:0]                  r_prefix, n_prefix;
    logic [7:0]                   r_op, n_op;
    logic                         r_halted, n_halted;

    logic [15:0]                  w_pos16;
    logic [15:0]                  w_line16;
    logic [15:0]                  w_start16;
    logic [31:0]                  w_pos_ext;
    logic [31:0]                  w_line_ext;
    logic [31:0]                  w_start_ext;
    logic                         w_kw_hit;
    logic [2:0]                   w_kw_idx;
    stt_pkg::t_result             w_word;
    stt_pkg::t_result             w_res_a, w_res_b;
    logic                         w_has_a, w_has_b;

    assign w_pos_ext   = 32'(r_pos);
    assign w_line_ext  = 32'(r_line);
    assign w_start_ext = 32'(r_start);
    assign w_pos16     = w_pos_ext[15:0];
    assign w_line16    = w_line_ext[15:0];
    assign w_start16   = w_start_ext[15:0];

    // Keyword lookup on the pending word; keywords are distinct, so at most one hits.
    always_comb begin
        w_kw_hit = 1'b0;
        w_kw_idx = '0;
        for (int i = 0; i < stt_pkg::KW_COUNT; i++) begin
            if (r_len <= 16'(stt_pkg::KW_MAX_LEN) && r_len == 16'(stt_pkg::KW_LEN[i])
                    && r_prefix == stt_pkg::KW_VALUE[i]) begin
                w_kw_hit = 1'b1;
                w_kw_idx = 3'(i);
            end
        end
        if (w_kw_hit) begin
            w_word = stt_pkg::make_result(stt_pkg::ST_TOKEN, stt_pkg::KIND_KEYWORD,
                w_start16, r_len, w_line16, w_kw_idx, 8'd0);
        end else begin
            w_word = stt_pkg::make_result(stt_pkg::ST_TOKEN, stt_pkg::KIND_IDENTIFIER,
                w_start16, r_len, w_line16, 3'd0, 8'd0);
        end
    end

    always_comb begin
        logic       again;
        logic       fail_a;
        logic [2:0] fail_status;
        logic [7:0] c;

        c           = i_text_byte;
        again       = 1'b0;
        fail_a      = 1'b0;
        fail_status = stt_pkg::ST_TOKEN;
        w_has_a     = 1'b0;
        w_has_b     = 1'b0;
        w_res_a     = '0;
        w_res_b     = '0;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_line      = r_line;
        n_start     = r_start;
        n_len       = r_len;
        n_prefix    = r_prefix;
        n_op        = r_op;
        n_halted    = r_halted;

        if (!r_halted) begin
            if (i_end_of_text) begin
                unique case (r_mode)
                    stt_pkg::MODE_WORD: begin
                        w_has_a = 1'b1;
                        w_res_a = w_word;
                    end
                    stt_pkg::MODE_NUM: begin
                        w_has_a = 1'b1;
                        w_res_a = stt_pkg::make_result(stt_pkg::ST_TOKEN,
                            stt_pkg::KIND_INTEGER, w_start16, r_len, w_line16, 3'd0, 8'd0);
                    end
                    stt_pkg::MODE_COLON: begin
                        fail_a      = 1'b1;
                        fail_status = stt_pkg::ST_COLON_SPACE;
                    end
                    stt_pkg::MODE_EQ1, stt_pkg::MODE_EQ2: begin
                        fail_a      = 1'b1;
                        fail_status = stt_pkg::ST_BAD_EQUALS;
                    end
                    stt_pkg::MODE_OP: begin
                        fail_a      = 1'b1;
                        fail_status = stt_pkg::ST_BAD_OPERATOR;
                    end
                    stt_pkg::MODE_SEMI: begin
                        fail_a      = 1'b1;
                        fail_status = stt_pkg::ST_SEMI_NEWLINE;
                    end
                    stt_pkg::MODE_IDLE: begin
                    end
                endcase
                n_mode = stt_pkg::MODE_IDLE;
                if (fail_a) begin
                    n_halted = 1'b1;
                end else begin
                    n_pos  = '0;
                    n_line = '0;
                end
            end else begin
                unique case (r_mode)
                    stt_pkg::MODE_WORD: begin
                        if (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c)) begin
                            if (r_len < 16'(stt_pkg::KW_MAX_LEN)) begin
                                n_prefix = {r_prefix[31:0], c};
                            end
                            if (r_len != stt_pkg::LENGTH_MAX) begin
                                n_len = r_len + 16'd1;
                            end
                        end else begin
                            w_has_a = 1'b1;
                            w_res_a = w_word;
                            again   = 1'b1;
                        end
                    end
                    stt_pkg::MODE_NUM: begin
                        priority if (stt_pkg::is_digit(c)) begin
                            if (r_len != stt_pkg::LENGTH_MAX) begin
                                n_len = r_len + 16'd1;
                            end
                        end else if (stt_pkg::is_alpha(c)) begin
                            fail_a      = 1'b1;
                            fail_status = stt_pkg::ST_DIGIT_LETTER;
                        end else begin
                            w_has_a = 1'b1;
                            w_res_a = stt_pkg::make_result(stt_pkg::ST_TOKEN,
                                stt_pkg::KIND_INTEGER, w_start16, r_len, w_line16, 3'd0, 8'd0);
                            again   = 1'b1;
                        end
                    end
                    stt_pkg::MODE_COLON: begin
                        if (c == stt_pkg::CH_SPACE) begin
                            w_has_a = 1'b1;
                            w_res_a = stt_pkg::make_result(stt_pkg::ST_TOKEN,
                                stt_pkg::KIND_COLON, w_start16, 16'd1, w_line16, 3'd0, 8'd0);
                            again   = 1'b1;
                        end else begin
                            fail_a      = 1'b1;
                            fail_status = stt_pkg::ST_COLON_SPACE;
                        end
                    end
                    stt_pkg::MODE_EQ1: begin
                        priority if (c == stt_pkg::CH_EQUALS) begin
                            n_mode = stt_pkg::MODE_EQ2;
                            n_len  = 16'd2;
                        end else if (stt_pkg::is_space(c)) begin
                            w_has_a = 1'b1;
                            w_res_a = stt_pkg::make_result(stt_pkg::ST_TOKEN,
                                stt_pkg::KIND_ASSIGN, w_start16, 16'd1, w_line16, 3'd0, 8'd0);
                            again   = 1'b1;
                        end else begin
                            fail_a      = 1'b1;
                            fail_status = stt_pkg::ST_BAD_EQUALS;
                        end
                    end
                    stt_pkg::MODE_EQ2: begin
                        if (stt_pkg::is_space(c)) begin
                            w_has_a = 1'b1;
                            w_res_a = stt_pkg::make_result(stt_pkg::ST_TOKEN,
                                stt_pkg::KIND_COMPARE, w_start16, 16'd2, w_line16, 3'd0, 8'd0);
                            again   = 1'b1;
                        end else begin
                            fail_a      = 1'b1;
                            fail_status = stt_pkg::ST_BAD_EQUALS;
                        end
                    end
                    stt_pkg::MODE_OP: begin
                        if (stt_pkg::is_space(c)) begin
                            w_has_a = 1'b1;
                            w_res_a = stt_pkg::make_result(stt_pkg::ST_TOKEN,
                                stt_pkg::KIND_OPERATOR, w_start16, 16'd1, w_line16, 3'd0, r_op);
                            again   = 1'b1;
                        end else begin
                            fail_a      = 1'b1;
                            fail_status = stt_pkg::ST_BAD_OPERATOR;
                        end
                    end
                    stt_pkg::MODE_SEMI: begin
                        if (c == stt_pkg::CH_LF) begin
                            w_has_a = 1'b1;
                            w_res_a = stt_pkg::make_result(stt_pkg::ST_TOKEN,
                                stt_pkg::KIND_SEMICOLON, w_start16, 16'd1, w_line16, 3'd0, 8'd0);
                            again   = 1'b1;
                        end else begin
                            fail_a      = 1'b1;
                            fail_status = stt_pkg::ST_SEMI_NEWLINE;
                        end
                    end
                    stt_pkg::MODE_IDLE: begin
                        again = 1'b1;
                    end
                endcase

                if (fail_a) begin
                    n_mode   = stt_pkg::MODE_IDLE;
                    n_halted = 1'b1;
                end

                // The byte that closed the previous token starts a new one.
                if (again) begin
                    n_mode  = stt_pkg::MODE_IDLE;
                    n_start = r_pos;
                    n_len   = 16'd1;
                    priority if (stt_pkg::is_alpha(c)) begin
                        n_mode   = stt_pkg::MODE_WORD;
                        n_prefix = {32'd0, c};
                    end else if (stt_pkg::is_digit(c)) begin
                        n_mode = stt_pkg::MODE_NUM;
                    end else if (stt_pkg::is_space(c)) begin
                        if (c == stt_pkg::CH_LF) begin
                            n_line = r_line + {{(LINE_BITS-1){1'b0}}, 1'b1};
                        end
                    end else if (c == stt_pkg::CH_COLON) begin
                        n_mode = stt_pkg::MODE_COLON;
                    end else if (c == stt_pkg::CH_LPAREN) begin
                        w_has_b = 1'b1;
                        w_res_b = stt_pkg::make_result(stt_pkg::ST_TOKEN,
                            stt_pkg::KIND_LPAREN, w_pos16, 16'd1, w_line16, 3'd0, 8'd0);
                    end else if (c == stt_pkg::CH_RPAREN) begin
                        w_has_b = 1'b1;
                        w_res_b = stt_pkg::make_result(stt_pkg::ST_TOKEN,
                            stt_pkg::KIND_RPAREN, w_pos16, 16'd1, w_line16, 3'd0, 8'd0);
                    end else if (c == stt_pkg::CH_EQUALS) begin
                        n_mode = stt_pkg::MODE_EQ1;
                    end else if (c == stt_pkg::CH_PLUS || c == stt_pkg::CH_MINUS
                            || c == stt_pkg::CH_STAR || c == stt_pkg::CH_SLASH) begin
                        n_mode = stt_pkg::MODE_OP;
                        n_op   = c;
                    end else if (c == stt_pkg::CH_SEMI) begin
                        n_mode = stt_pkg::MODE_SEMI;
                    end else begin
                        w_has_b  = 1'b1;
                        w_res_b  = stt_pkg::make_result(stt_pkg::ST_INVALID_CHAR,
                            stt_pkg::KIND_KEYWORD, w_pos16, 16'd0, w_line16, 3'd0, 8'd0);
                        n_halted = 1'b1;
                    end
                end

                n_pos = r_pos + {{(POSITION_BITS-1){1'b0}}, 1'b1};
            end

            if (fail_a) begin
                w_has_a = 1'b1;
                w_res_a = stt_pkg::make_result(fail_status, stt_pkg::KIND_KEYWORD,
                    w_pos16, 16'd0, w_line16, 3'd0, 8'd0);
            end
        end
    end

    // Pack the results of this transaction in order and mark the last one.
    always_comb begin
        o_push.count  = 2'({1'b0, w_has_a}) + 2'({1'b0, w_has_b});
        o_push.first  = w_has_a ? w_res_a : w_res_b;
        o_push.second = w_res_b;
        o_push.first.last_of_run  = ~(w_has_a & w_has_b);
        o_push.second.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= stt_pkg::MODE_IDLE;
            r_pos    <= '0;
            r_line   <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_prefix <= '0;
            r_op     <= '0;
            r_halted <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_line   <= n_line;
            r_start  <= n_start;
            r_len    <= n_len;
            r_prefix <= n_prefix;
            r_op     <= n_op;
            r_halted <= n_halted;
        end
    end

endmodule

`default_nettype wire

>>> src/stt_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module stt_result_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push_en,
    input  wire stt_pkg::t_push    i_push,
    output logic                   o_room,
    output logic                   o_valid,
    output stt_pkg::t_result       o_head,
    input  wire logic              i_pop
);

    localparam logic [stt_pkg::FIFO_PTR_BITS-1:0] PTR_ONE = stt_pkg::FIFO_PTR_BITS'(1);

    stt_pkg::t_result                     r_mem [stt_pkg::FIFO_DEPTH];
    logic [stt_pkg::FIFO_PTR_BITS-1:0]    r_wr, r_rd;
    logic [stt_pkg::FIFO_CNT_BITS-1:0]    r_count;
    logic [1:0]                           w_push_cnt;
    logic                                 w_pop;
    logic [stt_pkg::FIFO_PTR_BITS-1:0]    w_wr_next;

    assign w_push_cnt = i_push_en ? i_push.count : 2'd0;
    assign w_pop      = o_valid & i_pop;
    assign w_wr_next  = r_wr + PTR_ONE;
    assign o_valid    = r_count != '0;
    assign o_head     = r_mem[r_rd];
    // Room for the two results that one transaction can cause.
    assign o_room     = r_count <= stt_pkg::FIFO_CNT_BITS'(stt_pkg::FIFO_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (w_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (w_push_cnt == 2'd2) begin
            r_mem[w_wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + stt_pkg::FIFO_PTR_BITS'(w_push_cnt);
            r_rd    <= r_rd + stt_pkg::FIFO_PTR_BITS'(w_pop);
            r_count <= r_count + stt_pkg::FIFO_CNT_BITS'(w_push_cnt)
                       - stt_pkg::FIFO_CNT_BITS'(w_pop);
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/stt_token_checker.sv
`timescale 1ns / 1ps

module stt_token_checker
    import stt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    stt_in_if         i_text,
    stt_out_if        i_tok,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results_seen,
    output int        o_error_results
);

    // String literals land right-justified, so the first letter is the top used byte.
    localparam logic [39:0] KEYWORD_TEXT [8] = '{
        "let", "while", "if", "else", "int", "float", "char", "fn"
    };
    localparam int KEYWORD_CHARS [8] = '{3, 5, 2, 4, 3, 5, 4, 2};
    localparam int REPORT_LIMIT = 10;

    t_mode       mode;
    logic [15:0] pos;
    logic [15:0] cur_line;
    logic [15:0] tok_start;
    logic [15:0] tok_len;
    logic [39:0] prefix;
    logic [7:0]  op_char;
    logic        halted;

    t_result step_results[$];
    t_result expected_tokens[$];
    t_result observed;
    int      fails = 0;
    int      seen = 0;
    int      error_seen = 0;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void post_token(input logic [3:0] kind, input logic [15:0] start,
                                       input logic [15:0] len, input logic [2:0] kw,
                                       input logic [7:0] op);
        t_result r;
        r.status        = ST_TOKEN;
        r.token_kind    = kind;
        r.token_start   = start;
        r.token_length  = len;
        r.line_number   = cur_line;
        r.keyword_index = kw;
        r.operator_char = op;
        r.last_of_run   = 1'b0;
        step_results.push_back(r);
    endfunction

    // Error reports carry only the status, the offending position and the line.
    function automatic void raise_error(input logic [2:0] status);
        t_result r;
        r               = '0;
        r.status        = status;
        r.token_start   = pos;
        r.line_number   = cur_line;
        halted          = 1'b1;
        mode            = MODE_IDLE;
        step_results.push_back(r);
    endfunction

    function automatic void emit_word();
        logic [2:0] kw;
        logic       found;
        found = 1'b0;
        kw    = '0;
        for (int i = 0; i < 8; i++) begin
            if (!found && tok_len == 16'(KEYWORD_CHARS[i]) && prefix == KEYWORD_TEXT[i]) begin
                found = 1'b1;
                kw    = 3'(i);
            end
        end
        if (found) begin
            post_token(KIND_KEYWORD, tok_start, tok_len, kw, '0);
        end else begin
            post_token(KIND_IDENTIFIER, tok_start, tok_len, '0, '0);
        end
    endfunction

    function automatic void grow_token();
        if (tok_len != '1) tok_len++;
    endfunction

    // A byte seen with nothing pending starts a token, counts a line or is rejected.
    function automatic void open_token(input logic [7:0] c);
        mode      = MODE_IDLE;
        tok_start = pos;
        tok_len   = 16'd1;
        if (is_letter(c)) begin
            mode   = MODE_WORD;
            prefix = {32'd0, c};
        end else if (is_numeral(c)) begin
            mode = MODE_NUM;
        end else if (is_blank(c)) begin
            if (c == CH_LF) cur_line++;
        end else if (c == CH_COLON) begin
            mode = MODE_COLON;
        end else if (c == CH_LPAREN) begin
            post_token(KIND_LPAREN, pos, 16'd1, '0, '0);
        end else if (c == CH_RPAREN) begin
            post_token(KIND_RPAREN, pos, 16'd1, '0, '0);
        end else if (c == CH_EQUALS) begin
            mode = MODE_EQ1;
        end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
            mode    = MODE_OP;
            op_char = c;
        end else if (c == CH_SEMI) begin
            mode = MODE_SEMI;
        end else begin
            raise_error(ST_INVALID_CHAR);
        end
    endfunction

    function automatic void predict_tokens(input logic eot, input logic [7:0] c);
        logic reopen;
        reopen = 1'b0;
        step_results.delete();
        if (halted) return;
        if (eot) begin
            case (mode)
                MODE_WORD:          emit_word();
                MODE_NUM:           post_token(KIND_INTEGER, tok_start, tok_len, '0, '0);
                MODE_COLON:         raise_error(ST_COLON_SPACE);
                MODE_EQ1, MODE_EQ2: raise_error(ST_BAD_EQUALS);
                MODE_OP:            raise_error(ST_BAD_OPERATOR);
                MODE_SEMI:          raise_error(ST_SEMI_NEWLINE);
                default: ;
            endcase
            // A clean end of text rewinds position and line for the next text.
            if (!halted) begin
                mode     = MODE_IDLE;
                pos      = '0;
                cur_line = '0;
            end
        end else begin
            case (mode)
                MODE_WORD: begin
                    if (is_letter(c) || is_numeral(c)) begin
                        if (tok_len < 16'd5) prefix = {prefix[31:0], c};
                        grow_token();
                    end else begin
                        emit_word();
                        reopen = 1'b1;
                    end
                end
                MODE_NUM: begin
                    if (is_numeral(c)) begin
                        grow_token();
                    end else if (is_letter(c)) begin
                        raise_error(ST_DIGIT_LETTER);
                    end else begin
                        post_token(KIND_INTEGER, tok_start, tok_len, '0, '0);
                        reopen = 1'b1;
                    end
                end
                MODE_COLON: begin
                    if (c == CH_SPACE) begin
                        post_token(KIND_COLON, tok_start, 16'd1, '0, '0);
                        reopen = 1'b1;
                    end else begin
                        raise_error(ST_COLON_SPACE);
                    end
                end
                MODE_EQ1: begin
                    if (c == CH_EQUALS) begin
                        mode    = MODE_EQ2;
                        tok_len = 16'd2;
                    end else if (is_blank(c)) begin
                        post_token(KIND_ASSIGN, tok_start, 16'd1, '0, '0);
                        reopen = 1'b1;
                    end else begin
                        raise_error(ST_BAD_EQUALS);
                    end
                end
                MODE_EQ2: begin
                    if (is_blank(c)) begin
                        post_token(KIND_COMPARE, tok_start, 16'd2, '0, '0);
                        reopen = 1'b1;
                    end else begin
                        raise_error(ST_BAD_EQUALS);
                    end
                end
                MODE_OP: begin
                    if (is_blank(c)) begin
                        post_token(KIND_OPERATOR, tok_start, 16'd1, '0, op_char);
                        reopen = 1'b1;
                    end else begin
                        raise_error(ST_BAD_OPERATOR);
                    end
                end
                MODE_SEMI: begin
                    if (c == CH_LF) begin
                        post_token(KIND_SEMICOLON, tok_start, 16'd1, '0, '0);
                        reopen = 1'b1;
                    end else begin
                        raise_error(ST_SEMI_NEWLINE);
                    end
                end
                default: reopen = 1'b1;
            endcase
            if (reopen) open_token(c);
            pos++;
        end
        if (step_results.size() > 0) step_results[$].last_of_run = 1'b1;
        foreach (step_results[i]) expected_tokens.push_back(step_results[i]);
    endfunction

    function automatic void check_token(input t_result got);
        t_result want;
        seen++;
        if (got.status != ST_TOKEN) error_seen++;
        if (expected_tokens.size() == 0) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
                $display("Result %0d arrived with nothing expected: st=%0d kind=%0d start=%0d",
                         seen, got.status, got.token_kind, got.token_start);
            end
            return;
        end
        want = expected_tokens.pop_front();
        if (got !== want) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
                $display("Result %0d mismatch at %0t", seen, $realtime);
                $display("  expected st=%0d kind=%0d start=%0d len=%0d line=%0d kw=%0d op=%02h last=%0b",
                         want.status, want.token_kind, want.token_start, want.token_length,
                         want.line_number, want.keyword_index, want.operator_char,
                         want.last_of_run);
                $display("  actual   st=%0d kind=%0d start=%0d len=%0d line=%0d kw=%0d op=%02h last=%0b",
                         got.status, got.token_kind, got.token_start, got.token_length,
                         got.line_number, got.keyword_index, got.operator_char,
                         got.last_of_run);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode      = MODE_IDLE;
            pos       = '0;
            cur_line  = '0;
            tok_start = '0;
            tok_len   = '0;
            prefix    = '0;
            op_char   = '0;
            halted    = 1'b0;
            expected_tokens.delete();
        end else begin
            // A result never belongs to the byte accepted on the same edge.
            if (i_tok.valid && i_tok.ready) begin
                observed.status        = i_tok.status;
                observed.token_kind    = i_tok.token_kind;
                observed.token_start   = i_tok.token_start;
                observed.token_length  = i_tok.token_length;
                observed.line_number   = i_tok.line_number;
                observed.keyword_index = i_tok.keyword_index;
                observed.operator_char = i_tok.operator_char;
                observed.last_of_run   = i_tok.last_of_run;
                check_token(observed);
            end
            if (i_text.valid && i_text.ready) begin
                predict_tokens(i_text.end_of_text, i_text.text_byte);
            end
        end
        o_fail_count    <= fails;
        o_pending       <= expected_tokens.size();
        o_results_seen  <= seen;
        o_error_results <= error_seen;
    end

endmodule

>>> tb/sv/tb_source_text_tokenizer.sv
`timescale 1ns / 1ps

module tb_source_text_tokenizer;
    import stt_pkg::*;

    localparam int         MAX_GAP      = 15;
    localparam int         LONG_STALL   = 400;
    localparam int         RANDOM_BYTES = 1000;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         DRAIN_CYCLES = 16;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_BANG      = 8'h21;

    typedef enum int {
        PICK_KEYWORD, PICK_IDENT, PICK_NUMBER, PICK_OPERATOR, PICK_EQUALS,
        PICK_COLON, PICK_SEMI, PICK_LPAREN, PICK_RPAREN
    } t_pick;

    typedef enum int {
        BREAK_COLON, BREAK_EQUALS, BREAK_OPERATOR, BREAK_DIGITS, BREAK_SEMI,
        BREAK_INVALID, BREAK_AT_END, BREAK_WORD_INVALID
    } t_break;

    logic   i_clk;
    logic   i_rst_n;
    int     fail_count;
    int     pending;
    int     results_seen;
    int     error_results;
    int     bytes_sent = 0;
    int     random_bytes = 0;
    int     cycle_count = 0;
    logic   tx_steady = 1'b0;
    logic   rx_steady = 1'b0;
    logic   random_phase = 1'b0;
    logic   stall_done = 1'b0;
    logic   after_alnum = 1'b0;
    t_break break_case;
    string  keyword_list [8] = '{"let", "while", "if", "else", "int", "float", "char", "fn"};

    stt_in_if  text_ch ();
    stt_out_if tok_ch ();

    source_text_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_ch),
        .o_tok   (tok_ch)
    );

    stt_token_checker token_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_text          (text_ch),
        .i_tok           (tok_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_results_seen  (results_seen),
        .o_error_results (error_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding.", cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0") + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter();
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 9))
            0:       return CH_TAB;
            1:       return CH_LF;
            2:       return CH_VT;
            3:       return CH_FF;
            4:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] pick_invalid();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(128, 255));
            1:       return 8'($urandom_range(0, 8));
            2:       return 8'($urandom_range(14, 31));
            default: return CH_BANG;
        endcase
    endfunction

    task automatic send_byte(input logic eot, input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge i_clk);
            text_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= b;
        text_ch.end_of_text <= eot;
        do @(posedge i_clk); while (!text_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(1'b0, s[i]);
    endtask

    // Well-formed tokens; operators, equals, colon and semicolon carry their follower.
    task automatic send_random_token();
        t_pick pick;
        int    n;
        logic  separated;
        separated = $urandom_range(0, 3) != 0;
        if (separated) send_byte(1'b0, pick_blank());
        // A word or number may only be cut directly by a byte that cannot extend it.
        pick = t_pick'($urandom_range((after_alnum && !separated) ? PICK_OPERATOR : PICK_KEYWORD,
                                      PICK_RPAREN));
        after_alnum = 1'b0;
        case (pick)
            PICK_KEYWORD: begin
                send_text(keyword_list[$urandom_range(0, 7)]);
                if ($urandom_range(0, 3) == 0) send_byte(1'b0, rand_alnum());
                after_alnum = 1'b1;
            end
            PICK_IDENT: begin
                n = $urandom_range(1, 9);
                send_byte(1'b0, rand_letter());
                repeat (n - 1) send_byte(1'b0, rand_alnum());
                after_alnum = 1'b1;
            end
            PICK_NUMBER: begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(1'b0, rand_digit());
                after_alnum = 1'b1;
            end
            PICK_OPERATOR: begin
                send_byte(1'b0, pick_operator());
                send_byte(1'b0, pick_blank());
            end
            PICK_EQUALS: begin
                send_byte(1'b0, CH_EQUALS);
                if ($urandom_range(0, 1)) send_byte(1'b0, CH_EQUALS);
                send_byte(1'b0, pick_blank());
            end
            PICK_COLON: begin
                send_byte(1'b0, CH_COLON);
                send_byte(1'b0, CH_SPACE);
            end
            PICK_SEMI: begin
                send_byte(1'b0, CH_SEMI);
                send_byte(1'b0, CH_LF);
            end
            PICK_LPAREN: send_byte(1'b0, CH_LPAREN);
            default:     send_byte(1'b0, CH_RPAREN);
        endcase
    endtask

    // Any error halts the block until reset, so only one kind can be hit per run.
    task automatic send_breaking_sequence();
        break_case = t_break'($urandom_range(BREAK_COLON, BREAK_WORD_INVALID));
        send_byte(1'b0, CH_SPACE);
        case (break_case)
            BREAK_COLON: begin
                send_byte(1'b0, CH_COLON);
                send_byte(1'b0, rand_letter());
            end
            BREAK_EQUALS: begin
                send_byte(1'b0, CH_EQUALS);
                if ($urandom_range(0, 1)) send_byte(1'b0, CH_EQUALS);
                send_byte(1'b0, rand_alnum());
            end
            BREAK_OPERATOR: begin
                send_byte(1'b0, pick_operator());
                send_byte(1'b0, rand_alnum());
            end
            BREAK_DIGITS: begin
                send_byte(1'b0, rand_digit());
                send_byte(1'b0, rand_letter());
            end
            BREAK_SEMI: begin
                send_byte(1'b0, CH_SEMI);
                send_byte(1'b0, CH_SPACE);
            end
            BREAK_INVALID: send_byte(1'b0, pick_invalid());
            BREAK_AT_END: begin
                case ($urandom_range(0, 3))
                    0:       send_byte(1'b0, CH_COLON);
                    1:       send_byte(1'b0, CH_EQUALS);
                    2:       send_byte(1'b0, pick_operator());
                    default: send_byte(1'b0, CH_SEMI);
                endcase
                send_byte(1'b1, 8'($urandom_range(0, 255)));
            end
            default: begin
                send_text("elsewhere");
                send_byte(1'b0, pick_invalid());
            end
        endcase
    endtask

    initial begin : receiver
        int gap;
        tok_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            // One long hold-off lets the result queue fill and back up the input.
            if (random_phase && !stall_done) begin
                stall_done = 1'b1;
                gap        = LONG_STALL;
            end
            repeat (gap) begin
                @(negedge i_clk);
                tok_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            tok_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!tok_ch.valid);
        end
    end

    initial begin : stimulus
        int first;
        i_rst_n             = 1'b0;
        text_ch.valid       = 1'b0;
        text_ch.text_byte   = '0;
        text_ch.end_of_text = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every token kind, all six blanks, and tokens cut directly by a paren,
        // colon or blank; then end of text with nothing and with a number pending.
        send_text("if(a1 == 7)\tb: c;\n-\013=\014z\015");
        send_byte(1'b1, 8'hFF);
        send_text("9");
        send_byte(1'b1, 8'h80);

        random_phase = 1'b1;
        first        = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES) begin
            if ($urandom_range(0, 29) == 0) tx_steady = !tx_steady;
            if ($urandom_range(0, 49) == 0) begin
                send_byte(1'b1, 8'($urandom_range(0, 255)));
                after_alnum = 1'b0;
            end else begin
                send_random_token();
            end
        end
        random_bytes = bytes_sent - first;

        send_breaking_sequence();
        repeat (24) send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        @(negedge i_clk);
        text_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes: a directed token mix and %0d random bytes of well-formed text.",
                 bytes_sent, random_bytes);
        $display("Checked %0d results (%0d error reports); closing error case %s.",
                 results_seen, error_results, break_case.name());
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results never arrived.", fail_count, pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
src/stt_pkg.sv
src/stt_in_if.sv
src/stt_out_if.sv
src/stt_core.sv
src/stt_result_fifo.sv
src/source_text_tokenizer.sv
tb/sv/stt_token_checker.sv
tb/sv/tb_source_text_tokenizer.sv
